@@ rtl/tct_pkg.sv @@
// tct_pkg: shared types, operation and register codes for the console core
// no dependencies
package tct_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    OP_PUTC  = 3'd0,
    OP_SETC  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_CUR_ON  = 3'd3,
    OP_CUR_OFF = 3'd4,
    OP_READ  = 3'd5,
    OP_NOP6  = 3'd6,
    OP_NOP7  = 3'd7
  } op_t;

  localparam logic REG_TEXT_ATTR   = 1'b0;
  localparam logic REG_CURSOR_ATTR = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,      // clearing pass over the whole store after reset
    ST_IDLE,
    ST_DECODE,
    ST_HIDE,      // write text attribute at old cursor, keep character
    ST_HIDE_RD,
    ST_WRCH,      // backspace: write a space at a cell, keep attribute
    ST_WRCH_RD,
    ST_SCR_RD,    // scroll: read cell below
    ST_SCR_WR,    // scroll: write cell above
    ST_FILL,      // fill blanks from index to end
    ST_SHOW_RD,
    ST_SHOW,
    ST_READ_RD,
    ST_READ,
    ST_OUT,
    ST_REDRAW     // cursor attr write: per-terminal redraw
  } state_t;

endpackage

@@ rtl/text_console_terminal_core.sv @@
// text_console_terminal_core: multi-terminal text console, one shared cell-store port
// depends on tct_pkg and tct_ram
// a scroll first moves the rows of its terminal up and blanks the last row, a clear blanks the
// whole terminal; next accept after the result is taken
// after reset a clearing pass writes every cell; cfg taken in idle
module text_console_terminal_core #(
  parameter int ROWS      = 25,
  parameter int COLUMNS   = 80,
  parameter int TERMINALS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[2:0], terminal[4:3], character[12:5], column[19:13], row[24:20], pad
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_column[6:0], cursor_row[11:7], cell_character[19:12], cell_attribute[27:20]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import tct_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int DEPTH = TERMINALS * CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  state_t state_r, state_nxt;

  logic [7:0]  text_attr_r, cursor_attr_r;
  logic [CW-1:0] ccol_r [TERMINALS];
  logic [RW-1:0] crow_r [TERMINALS];
  logic [TERMINALS-1:0] cen_r;

  // item registers
  op_t          op_r;
  logic [TW-1:0] term_r;
  logic         tvalid_r;
  logic [7:0]   ch_r;
  logic [CW-1:0] icol_r;
  logic [RW-1:0] irow_r;

  // walk registers
  logic [AW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] idx_r, idx_nxt;     // cell index within terminal
  logic [7:0]  wch_r, wch_nxt;
  logic [CW-1:0] ncol_r, ncol_nxt;
  logic [RW-1:0] nrow_r, nrow_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [TW-1:0] rt_r, rt_nxt;
  logic          rd_r, rd_nxt;        // redraw path return marker

  logic        we;
  logic [15:0] wdata, rdata;
  logic [AW-1:0] raddr;

  logic [31:0] out_r, out_nxt;
  logic        ov_r, ov_nxt;

  tct_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(raddr), .wdata(wdata), .rdata(rdata)
  );

  // decoded input fields
  logic [2:0] in_op;
  logic [1:0] in_term;
  logic [6:0] in_col;
  logic [4:0] in_row;
  assign in_op   = in_tdata[2:0];
  assign in_term = in_tdata[4:3];
  assign in_col  = in_tdata[19:13];
  assign in_row  = in_tdata[24:20];

  function automatic logic [AW-1:0] cell_addr(input logic [TW-1:0] t,
                                              input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    logic [AW-1:0] a;
    a = AW'(t) * AW'(CELLS) + AW'(r) * AW'(COLUMNS) + AW'(c);
    return a;
  endfunction

  // a pending register write wins the idle cycle over an input transaction
  assign in_tready = (state_r == ST_IDLE) && !ov_r && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  logic [CW-1:0] cur_c;
  logic [RW-1:0] cur_r;
  assign cur_c = ccol_r[term_r];
  assign cur_r = crow_r[term_r];

  logic last_cell, last_row;
  assign last_row  = (cur_r == RW'(ROWS - 1));
  assign last_cell = last_row && (cur_c == CW'(COLUMNS - 1));

  logic set_cur;
  logic set_en, en_val;
  logic redraw_go;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    idx_nxt   = idx_r;
    wch_nxt   = wch_r;
    ncol_nxt  = ncol_r;
    nrow_nxt  = nrow_r;
    hold_nxt  = hold_r;
    rt_nxt    = rt_r;
    rd_nxt    = rd_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !out_tready;
    we        = 1'b0;
    wdata     = {text_attr_r, CH_SPACE};
    raddr     = addr_r;
    set_cur   = 1'b0;
    set_en    = 1'b0;
    en_val    = 1'b0;
    redraw_go = cfg_valid && cfg_ready && (cfg_index == REG_CURSOR_ATTR);
    unique case (state_r)
      ST_INIT: begin
        we = 1'b1;
        wdata = {text_attr_r, CH_SPACE};
        if (idx_r == PW'(0) && cen_r[rt_r]) wdata = {cursor_attr_r, CH_SPACE};
        if (idx_r == PW'(CELLS - 1)) begin
          idx_nxt = '0;
          if (rt_r == TW'(TERMINALS - 1)) begin
            state_nxt = ST_IDLE;
            rt_nxt = '0;
          end else rt_nxt = rt_r + 1'b1;
        end else idx_nxt = idx_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (state_nxt == ST_IDLE) addr_nxt = '0;
      end
      ST_IDLE: begin
        if (redraw_go) begin
          rt_nxt = '0;
          state_nxt = ST_REDRAW;
        end else if (in_tvalid && in_tready) state_nxt = ST_DECODE;
      end
      ST_REDRAW: begin
        // one terminal at a time: read its cursor cell, then rewrite it with the cursor attribute if its cursor is on
        raddr = cell_addr(rt_r, crow_r[rt_r], ccol_r[rt_r]);
        state_nxt = ST_SHOW_RD;
        rd_nxt = 1'b1;
      end
      ST_DECODE: begin
        ncol_nxt = cur_c;
        nrow_nxt = cur_r;
        rd_nxt = 1'b0;
        if (!tvalid_r) state_nxt = ST_OUT;
        else begin
          unique case (op_r)
            OP_PUTC: begin
              if (ch_r == CH_NUL) state_nxt = ST_OUT;
              else if (ch_r == CH_BS && cur_c == '0 && cur_r == '0) state_nxt = ST_OUT;
              else begin
                addr_nxt = cell_addr(term_r, cur_r, cur_c);
                state_nxt = ST_HIDE_RD;
              end
            end
            OP_SETC, OP_CLEAR, OP_CUR_OFF: begin
              addr_nxt = cell_addr(term_r, cur_r, cur_c);
              state_nxt = ST_HIDE_RD;
            end
            OP_CUR_ON: begin
              set_en = 1'b1; en_val = 1'b1;
              state_nxt = ST_SHOW_RD;
            end
            OP_READ: begin
              addr_nxt = cell_addr(term_r, irow_r, icol_r);
              state_nxt = ST_READ_RD;
            end
            OP_NOP6, OP_NOP7: state_nxt = ST_OUT;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_HIDE_RD: state_nxt = ST_HIDE;
      ST_HIDE: begin
        we = 1'b1;
        wdata = {text_attr_r, rdata[7:0]};
        state_nxt = ST_SHOW_RD;
        unique case (op_r)
          OP_CUR_OFF: begin
            set_en = 1'b1; en_val = 1'b0;
            state_nxt = ST_OUT;
          end
          OP_SETC: begin
            ncol_nxt = icol_r; nrow_nxt = irow_r; set_cur = 1'b1;
          end
          OP_CLEAR: begin
            idx_nxt = '0;
            addr_nxt = cell_addr(term_r, '0, '0);
            state_nxt = ST_FILL;
          end
          default: begin
            if (ch_r == CH_LF) begin
              if (last_row) begin
                idx_nxt = '0;
                addr_nxt = cell_addr(term_r, '0, '0);
                ncol_nxt = '0; nrow_nxt = RW'(ROWS - 1);
                state_nxt = ST_SCR_RD;
              end else begin
                ncol_nxt = '0; nrow_nxt = cur_r + 1'b1; set_cur = 1'b1;
              end
            end else if (ch_r == CH_BS) begin
              if (cur_c == '0) begin
                ncol_nxt = CW'(COLUMNS - 1); nrow_nxt = cur_r - 1'b1;
              end else ncol_nxt = cur_c - 1'b1;
              wch_nxt = CH_SPACE;
              state_nxt = ST_WRCH_RD;
            end else begin
              // printable: write char here (keeping text attr, just written)
              we = 1'b1;
              wdata = {text_attr_r, ch_r};
              if (last_cell) begin
                idx_nxt = '0;
                addr_nxt = cell_addr(term_r, '0, '0);
                ncol_nxt = '0; nrow_nxt = RW'(ROWS - 1);
                state_nxt = ST_SCR_RD;
              end else begin
                if (cur_c == CW'(COLUMNS - 1)) begin
                  ncol_nxt = '0; nrow_nxt = cur_r + 1'b1;
                end else ncol_nxt = cur_c + 1'b1;
                set_cur = 1'b1;
              end
            end
          end
        endcase
        if (set_cur) addr_nxt = cell_addr(term_r, nrow_nxt, ncol_nxt);
        if (state_nxt == ST_WRCH_RD) addr_nxt = cell_addr(term_r, nrow_nxt, ncol_nxt);
      end
      ST_WRCH_RD: state_nxt = ST_WRCH;
      ST_WRCH: begin
        we = 1'b1;
        wdata = {rdata[15:8], wch_r};
        set_cur = 1'b1;
        state_nxt = ST_SHOW_RD;
      end
      ST_SCR_RD: begin
        raddr = addr_r + AW'(COLUMNS);
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we = 1'b1;
        wdata = rdata;
        addr_nxt = addr_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == PW'(CELLS - COLUMNS - 1)) state_nxt = ST_FILL;
        else state_nxt = ST_SCR_RD;
      end
      ST_FILL: begin
        we = 1'b1;
        wdata = {text_attr_r, CH_SPACE};
        addr_nxt = addr_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == PW'(CELLS - 1)) begin
          if (op_r == OP_CLEAR) begin
            ncol_nxt = '0; nrow_nxt = '0;
          end
          set_cur = 1'b1;
          addr_nxt = cell_addr(term_r, nrow_nxt, ncol_nxt);
          state_nxt = ST_SHOW_RD;
        end
      end
      ST_SHOW_RD: begin
        if (rd_r) raddr = cell_addr(rt_r, crow_r[rt_r], ccol_r[rt_r]);
        else raddr = cell_addr(term_r, crow_r[term_r], ccol_r[term_r]);
        addr_nxt = raddr;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (rd_r) begin
          we = cen_r[rt_r];
          wdata = {cursor_attr_r, rdata[7:0]};
          if (rt_r == TW'(TERMINALS - 1)) begin
            rd_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            rt_nxt = rt_r + 1'b1;
            state_nxt = ST_REDRAW;
          end
        end else begin
          we = cen_r[term_r];
          wdata = {cursor_attr_r, rdata[7:0]};
          state_nxt = ST_OUT;
        end
      end
      ST_READ_RD: state_nxt = ST_READ;
      ST_READ: begin
        hold_nxt = rdata;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r) begin
          out_nxt = '0;
          if (tvalid_r) begin
            out_nxt[6:0]  = 7'(ccol_r[term_r]);
            out_nxt[11:7] = 5'(crow_r[term_r]);
            if (op_r == OP_READ) out_nxt[27:12] = hold_r;
          end
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      text_attr_r <= 8'd7;
      cursor_attr_r <= 8'd112;
      cen_r <= '1;
      ov_r <= 1'b0;
      addr_r <= '0;
      idx_r <= '0;
      rt_r <= '0;
      rd_r <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        ccol_r[i] <= '0;
        crow_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      addr_r <= addr_nxt;
      idx_r <= idx_nxt;
      rt_r <= rt_nxt;
      rd_r <= rd_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEXT_ATTR) text_attr_r <= cfg_data;
        else cursor_attr_r <= cfg_data;
      end
      if (set_en) cen_r[term_r] <= en_val;
      if (set_cur) begin
        ccol_r[term_r] <= ncol_nxt;
        crow_r[term_r] <= nrow_nxt;
      end
    end
  end

  logic [6:0] cl_col;
  logic [4:0] cl_row;
  always_comb begin
    cl_col = (in_col > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : in_col;
    cl_row = (in_row > 5'(ROWS - 1)) ? 5'(ROWS - 1) : in_row;
  end

  always_ff @(posedge clk) begin
    wch_r  <= wch_nxt;
    ncol_r <= ncol_nxt;
    nrow_r <= nrow_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    if (in_tvalid && in_tready) begin
      op_r     <= op_t'(in_op);
      term_r   <= TW'(in_term);
      tvalid_r <= (32'(in_term) < TERMINALS);
      ch_r     <= in_tdata[12:5];
      icol_r   <= CW'(cl_col);
      irow_r   <= RW'(cl_row);
    end
  end

  // output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // no input taken while a result is pending
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted with result pending");
  // cursor row stays on the grid
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:7] <= 5'(ROWS - 1))
    else $error("cursor row out of range");

endmodule

@@ rtl/tct_ram.sv @@
// tct_ram: generic single-port ram with registered read
// no dependencies
module tct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ verif/text_console_terminal_core_tb.sv @@
// text_console_terminal_core_tb: self-checking bench for the multi-terminal text console
// depends on tct_pkg and text_console_terminal_core; tracks cell stores and cursors itself
module text_console_terminal_core_tb;
  import tct_pkg::*;

  localparam int ROWS      = 25;
  localparam int COLUMNS   = 80;
  localparam int TERMINALS = 4;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int IDLE_LIMIT = 60000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  text_console_terminal_core #(
    .ROWS(ROWS), .COLUMNS(COLUMNS), .TERMINALS(TERMINALS)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // one console response: cursor after the operation plus the cell read
  // members listed from the top bit down, cursor column in the low bits
  typedef struct packed {
    logic [7:0] cell_attr;
    logic [7:0] cell_ch;
    logic [4:0] cur_row;
    logic [6:0] cur_col;
  } console_resp_t;

  // shadow of the console state
  logic [15:0] screen [TERMINALS][CELLS];
  int          cursor_at [TERMINALS];
  bit          cursor_shown [TERMINALS];
  logic [7:0]  text_attr_q;
  logic [7:0]  cursor_attr_q;

  console_resp_t pending_resp[$];
  int            error_count;
  int            idle_cycles;
  int            burst_left;
  bit            no_gaps;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------- shadow model
  function automatic void hide_cursor(int t);
    screen[t][cursor_at[t]][15:8] = text_attr_q;
  endfunction

  function automatic void show_cursor(int t);
    if (cursor_shown[t]) screen[t][cursor_at[t]][15:8] = cursor_attr_q;
  endfunction

  function automatic void blank_from(int t, int first);
    for (int i = first; i < CELLS; i++) screen[t][i] = {text_attr_q, CH_SPACE};
  endfunction

  function automatic void scroll_screen(int t);
    for (int i = 0; i + COLUMNS < CELLS; i++) screen[t][i] = screen[t][i + COLUMNS];
    blank_from(t, CELLS - COLUMNS);
  endfunction

  function automatic void place_cursor(int t, int idx);
    hide_cursor(t);
    cursor_at[t] = idx;
    show_cursor(t);
  endfunction

  function automatic void reset_console();
    text_attr_q   = 8'd7;
    cursor_attr_q = 8'd112;
    for (int t = 0; t < TERMINALS; t++) begin
      blank_from(t, 0);
      cursor_at[t]    = 0;
      cursor_shown[t] = 1'b1;
      show_cursor(t);
    end
  endfunction

  function automatic void console_put(int t, logic [7:0] ch);
    int pos;
    pos = cursor_at[t];
    if (ch == CH_NUL) return;
    if (ch == CH_LF) begin
      if (pos / COLUMNS == ROWS - 1) begin
        hide_cursor(t);
        scroll_screen(t);
        place_cursor(t, (ROWS - 1) * COLUMNS);
      end else begin
        place_cursor(t, (pos / COLUMNS + 1) * COLUMNS);
      end
      return;
    end
    if (ch == CH_BS) begin
      if (pos != 0) begin
        hide_cursor(t);
        cursor_at[t] = pos - 1;
        screen[t][pos - 1][7:0] = CH_SPACE;
        show_cursor(t);
      end
      return;
    end
    hide_cursor(t);
    screen[t][pos][7:0] = ch;
    if (pos >= CELLS - 1) begin
      scroll_screen(t);
      cursor_at[t] = CELLS - COLUMNS;
    end else begin
      cursor_at[t] = pos + 1;
    end
    show_cursor(t);
  endfunction

  function automatic console_resp_t console_apply(op_t op, int t, logic [7:0] ch,
                                                  int col, int row);
    console_resp_t r;
    r = '0;
    if (col > COLUMNS - 1) col = COLUMNS - 1;
    if (row > ROWS - 1) row = ROWS - 1;
    case (op)
      OP_PUTC: console_put(t, ch);
      OP_SETC: place_cursor(t, row * COLUMNS + col);
      OP_CLEAR: begin
        hide_cursor(t);
        blank_from(t, 0);
        cursor_at[t] = 0;
        show_cursor(t);
      end
      OP_CUR_ON: begin
        cursor_shown[t] = 1'b1;
        show_cursor(t);
      end
      OP_CUR_OFF: begin
        cursor_shown[t] = 1'b0;
        hide_cursor(t);
      end
      OP_READ: begin
        r.cell_ch   = screen[t][row * COLUMNS + col][7:0];
        r.cell_attr = screen[t][row * COLUMNS + col][15:8];
      end
      default: ;
    endcase
    r.cur_col = 7'(cursor_at[t] % COLUMNS);
    r.cur_row = 5'(cursor_at[t] / COLUMNS);
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  // sends one transaction; bursts of random length separated by random gaps
  task automatic send_op(op_t op, logic [1:0] t, logic [7:0] ch, logic [6:0] col,
                         logic [4:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, row, col, ch, t, op};
    do @(posedge clk); while (!in_tready);
    pending_resp.push_back(console_apply(op, t, ch, col, row));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // register writes only go in with the console idle
  task automatic write_reg(logic idx, logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TEXT_ATTR) begin
      text_attr_q = value;
    end else begin
      cursor_attr_q = value;
      for (int t = 0; t < TERMINALS; t++) show_cursor(t);
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    console_resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[27:0];
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected transaction", int'(got), 0);
      end else begin
        want = pending_resp.pop_front();
        if (got.cur_col != want.cur_col)
          report_mismatch("cursor_column", int'(got.cur_col), int'(want.cur_col));
        if (got.cur_row != want.cur_row)
          report_mismatch("cursor_row", int'(got.cur_row), int'(want.cur_row));
        if (got.cell_ch != want.cell_ch)
          report_mismatch("cell_character", int'(got.cell_ch), int'(want.cell_ch));
        if (got.cell_attr != want.cell_attr)
          report_mismatch("cell_attribute", int'(got.cell_attr), int'(want.cell_attr));
      end
    end
  end

  // receiver stall pattern: a rotating 16-bit mask, swapped periodically for all ones or a random one
  logic [15:0] stall_mask;
  int          stall_tick;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_mask <= 16'hffff;
      stall_tick <= 0;
      out_tready <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 255) begin
        case ($urandom_range(0, 3))
          0: stall_mask <= 16'hffff;
          1: stall_mask <= 16'(($urandom() | $urandom()));
          default: stall_mask <= 16'($urandom());
        endcase
      end else begin
        stall_mask <= {stall_mask[14:0], stall_mask[15]};
      end
      out_tready <= stall_mask[15];
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_terminal_core_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // field extremes, every operation, newline/backspace/nul, clamping, both scroll paths
  task automatic test_directed();
    send_op(OP_READ, 2'd0, 8'h00, 7'd0, 5'd0);          // cursor cell at reset
    send_op(OP_PUTC, 2'd0, 8'h41, 7'd0, 5'd0);
    send_op(OP_PUTC, 2'd0, CH_NUL, 7'd0, 5'd0);
    send_op(OP_PUTC, 2'd1, CH_BS, 7'd0, 5'd0);          // backspace at cell zero
    send_op(OP_PUTC, 2'd0, CH_BS, 7'd0, 5'd0);
    send_op(OP_PUTC, 2'd0, 8'hff, 7'd127, 5'd31);
    send_op(OP_PUTC, 2'd0, CH_LF, 7'd0, 5'd0);
    send_op(OP_SETC, 2'd2, 8'h00, 7'd127, 5'd31);       // clamps to last cell
    send_op(OP_PUTC, 2'd2, 8'h5a, 7'd0, 5'd0);          // write at last cell scrolls
    send_op(OP_READ, 2'd2, 8'h00, 7'd79, 5'd23);
    send_op(OP_PUTC, 2'd2, CH_LF, 7'd0, 5'd0);          // newline on last row scrolls
    send_op(OP_SETC, 2'd3, 8'h00, 7'd79, 5'd0);
    send_op(OP_PUTC, 2'd3, 8'h80, 7'd0, 5'd0);          // wraps to next row
    send_op(OP_CUR_OFF, 2'd3, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 2'd3, 8'h00, 7'd0, 5'd1);
    send_op(OP_CUR_ON, 2'd3, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 2'd3, 8'h00, 7'd0, 5'd1);
    send_op(OP_NOP6, 2'd1, 8'hff, 7'd127, 5'd31);
    send_op(OP_NOP7, 2'd1, 8'hff, 7'd127, 5'd31);
    send_op(OP_READ, 2'd0, 8'hff, 7'd127, 5'd31);
    send_op(OP_CLEAR, 2'd0, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 2'd0, 8'h00, 7'd1, 5'd0);
  endtask

  // random operations, weighted toward text output with occasional scrolls
  task automatic test_random(int count);
    int   pick;
    op_t  op;
    logic [7:0] ch;
    for (int n = 0; n < count; n++) begin
      if ((n % 150) == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom());
      if (pick < 58) begin
        op = OP_PUTC;
        case ($urandom_range(0, 19))
          0: ch = CH_LF;
          1: ch = CH_BS;
          2: ch = CH_NUL;
          default: ;
        endcase
      end else if (pick < 70) op = OP_SETC;
      else if (pick < 71) op = OP_CLEAR;
      else if (pick < 76) op = OP_CUR_ON;
      else if (pick < 81) op = OP_CUR_OFF;
      else if (pick < 97) op = OP_READ;
      else op = ($urandom_range(0, 1) != 0) ? OP_NOP6 : OP_NOP7;
      send_op(op, 2'($urandom()), ch, 7'($urandom()), 5'($urandom()));
    end
  endtask

  // register sweep with the extremes, each pair of settings followed by traffic
  task automatic test_registers();
    write_reg(REG_TEXT_ATTR, 8'hff);
    write_reg(REG_CURSOR_ATTR, 8'h00);
    test_random(300);
    write_reg(REG_TEXT_ATTR, 8'h00);
    write_reg(REG_CURSOR_ATTR, 8'hff);
    test_random(300);
    write_reg(REG_TEXT_ATTR, 8'($urandom()));
    write_reg(REG_CURSOR_ATTR, 8'($urandom()));
    test_random(300);
  endtask

  initial begin
    error_count = 0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    reset_console();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(400);
    drain();                    // full drain mid-stream before continuing
    test_random(400);
    test_registers();
    drain();

    if (error_count == 0)
      $display("text_console_terminal_core_tb: done, clean");
    else
      $display("text_console_terminal_core_tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tct_pkg.sv
rtl/tct_ram.sv
rtl/text_console_terminal_core.sv
verif/text_console_terminal_core_tb.sv
